[hw/rtl/als_pkg.sv]
`timescale 1ns / 1ps

package als_pkg;

  // Angle formats
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int INT_FRAC        = 30;
  localparam int ZSH             = INT_FRAC - ANGLE_FRAC_BITS;
  localparam int ANG_W           = 15;
  localparam int STATE_W         = 16;
  localparam int Z_W             = 32;

  // CORDIC sequencing
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int STEPS        = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int ITER_W       = (STEPS > 1) ? $clog2(STEPS) : 1;

  // vector datapath: holds 2*L*c + w*s times the CORDIC gain with margin
  localparam int VW = 46;

  // shared multiplier
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // lag gain is Q0.16
  localparam int LAG_FRAC = 16;
  localparam logic signed [MUL_P_W-1:0] LAG_RND = MUL_P_W'(1) << (LAG_FRAC - 1);

  // pi/2 in Q32, rounded to the angle format
  localparam longint HALF_PI_Q32 = 64'sd6746518852;
  localparam longint HALF_PI_L   =
    (HALF_PI_Q32 + (64'sd1 << (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);
  localparam logic signed [STATE_W-1:0] HALF_PI = STATE_W'(HALF_PI_L);

  // config registers
  localparam int CFG_DW     = 32;
  localparam int APB_ADDR_W = 4;
  localparam logic [1:0] REG_WHEELBASE = 2'd0;
  localparam logic [1:0] REG_TRACK     = 2'd1;
  localparam logic [1:0] REG_LAG_GAIN  = 2'd2;
  localparam logic [11:0] WHEELBASE_RST = 12'd1530;
  localparam logic [11:0] TRACK_RST     = 12'd1200;
  localparam logic [15:0] LAG_GAIN_RST  = 16'd655;

  typedef struct packed {
    logic [11:0] wheelbase;
    logic [11:0] track;
    logic [15:0] lag_gain;
  } cfg_t;

  typedef enum logic {
    CM_ROTATE,
    CM_VECTOR
  } cmode_t;

  typedef struct packed {
    cmode_t              mode;
    logic [ITER_W-1:0]   shift;
  } step_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAG_MUL,
    ST_LAG_UPD,
    ST_ROT,
    ST_MUL_LS,
    ST_MUL_LC,
    ST_MUL_WS,
    ST_MUL_END,
    ST_VEC_INIT,
    ST_VEC,
    ST_VEC_END,
    ST_DONE
  } state_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sh3243F6A8;
      5'd1:    v = 32'sh1DAC6705;
      5'd2:    v = 32'sh0FADBAFC;
      5'd3:    v = 32'sh07F56EA6;
      5'd4:    v = 32'sh03FEAB76;
      5'd5:    v = 32'sh01FFD55B;
      5'd6:    v = 32'sh00FFFAAA;
      5'd7:    v = 32'sh007FFF55;
      5'd8:    v = 32'sh003FFFEA;
      5'd9:    v = 32'sh001FFFFD;
      5'd10:   v = 32'sh000FFFFF;
      5'd11:   v = 32'sh0007FFFF;
      5'd12:   v = 32'sh0003FFFF;
      5'd13:   v = 32'sh0001FFFF;
      5'd14:   v = 32'sh0000FFFF;
      5'd15:   v = 32'sh00007FFF;
      5'd16:   v = 32'sh00003FFF;
      5'd17:   v = 32'sh00001FFF;
      5'd18:   v = 32'sh00000FFF;
      5'd19:   v = 32'sh000007FF;
      5'd20:   v = 32'sh000003FF;
      5'd21:   v = 32'sh000001FF;
      5'd22:   v = 32'sh000000FF;
      5'd23:   v = 32'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/als_cfg_regs.sv]
`timescale 1ns / 1ps

module als_cfg_regs import als_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic [1:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheelbase <= WHEELBASE_RST;
      cfg_r.track     <= TRACK_RST;
      cfg_r.lag_gain  <= LAG_GAIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_WHEELBASE: cfg_r.wheelbase <= pwdata[11:0];
        REG_TRACK:     cfg_r.track     <= pwdata[11:0];
        REG_LAG_GAIN:  cfg_r.lag_gain  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WHEELBASE: prdata = CFG_DW'(cfg_r.wheelbase);
      REG_TRACK:     prdata = CFG_DW'(cfg_r.track);
      REG_LAG_GAIN:  prdata = CFG_DW'(cfg_r.lag_gain);
      default:       prdata = '0;
    endcase
  end

endmodule

[hw/rtl/als_mul.sv]
`timescale 1ns / 1ps

module als_mul import als_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_r;

  // product registered, read in the cycle after the operands
  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_r;

endmodule

[hw/rtl/als_cordic_step.sv]
`timescale 1ns / 1ps

module als_cordic_step import als_pkg::*; (
  input  logic signed [VW-1:0]  x_i,
  input  logic signed [VW-1:0]  y_i,
  input  logic signed [Z_W-1:0] z_i,
  input  step_ctl_t             ctl,
  output logic signed [VW-1:0]  x_o,
  output logic signed [VW-1:0]  y_o,
  output logic signed [Z_W-1:0] z_o
);

  logic signed [VW-1:0]  xs;
  logic signed [VW-1:0]  ys;
  logic signed [Z_W-1:0] ang;
  logic                  ccw;
  logic                  y_pos;

  assign xs    = x_i >>> ctl.shift;
  assign ys    = y_i >>> ctl.shift;
  assign ang   = atan_q30(ATAN_IDX_W'(ctl.shift));
  assign y_pos = !y_i[VW-1] && (y_i != '0);

  // rotate: turn toward z = 0; vector: turn toward y = 0
  assign ccw = (ctl.mode == CM_ROTATE) ? !z_i[Z_W-1] : !y_pos;

  assign x_o = ccw ? (x_i - ys) : (x_i + ys);
  assign y_o = ccw ? (y_i + xs) : (y_i - xs);
  assign z_o = ccw ? (z_i - ang) : (z_i + ang);

endmodule

[hw/rtl/ackermann_steer_lag_step_unit.sv]
`timescale 1ns / 1ps

// Ackermann steering step with a first-order lagged steering column.
// Input channel (in_valid/in_ready): one word per tick, in_steer_command,
// target column angle in signed Q2.13 radians.
// Output channel (out_valid/out_ready): one word per input word, holding the
// updated column angle and the left and right front wheel angles (Q2.13).
// Config: APB-style port, pready always high; wheelbase_mm at 0x0,
// track_mm at 0x4, lag_gain at 0x8. Write only while the block is idle.
// Timing: in_ready is high only in idle. From acceptance to out_valid a word
// passes through the lag multiply and update, 16 rotation steps, the
// multiplier states, two vectoring passes and a load state; in_ready
// returns with out_valid, so a new word is taken only when the last is
// done. A zero column angle skips the CORDIC work; a zero x component
// skips one vectoring pass. The sequence is set by the one shared CORDIC
// step unit and the one shared multiplier, used in turn under the sequencer.
// Stall: the result sits in an output register; the next word is accepted
// while it waits, and that word's result holds in the load state until the
// register is taken.
// Reset (rst_n, synchronous): column angle cleared, registers to defaults,
// out_valid low.

module ackermann_steer_lag_step_unit import als_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input word
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ANG_W-1:0]  in_steer_command,
  // result word
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ANG_W-1:0]  out_column_angle,
  output logic signed [ANG_W-1:0]  out_left_wheel_angle,
  output logic signed [ANG_W-1:0]  out_right_wheel_angle,
  // config port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  localparam logic signed [VW-1:0]  ROT_X0  = VW'(1) << 28;
  localparam logic signed [Z_W:0]   VEC_RND = (Z_W+1)'(1) << (ZSH - 1);
  localparam logic [ITER_W-1:0]     ITER_LAST = ITER_W'(STEPS - 1);

  function automatic logic signed [STATE_W-1:0] clamp_hp(input logic signed [Z_W:0] v);
    logic signed [STATE_W-1:0] r;
    if (v > HALF_PI) begin
      r = HALF_PI;
    end else if (v < -HALF_PI) begin
      r = -HALF_PI;
    end else begin
      r = STATE_W'(v);
    end
    return r;
  endfunction

  cfg_t cfg;

  state_t state_r, state_nxt;

  logic signed [ANG_W-1:0]   cmd_r;
  logic signed [STATE_W-1:0] column_r;
  logic signed [VW-1:0]      cx_r, cy_r;
  logic signed [Z_W-1:0]     cz_r;
  logic [ITER_W-1:0]         iter_r;
  logic                      side_r;     // 0: left wheel, 1: right wheel
  logic signed [VW-1:0]      ls_r, lc_r, ws_r;
  logic signed [ANG_W-1:0]   left_r, right_r;

  logic                      out_valid_r;
  logic signed [ANG_W-1:0]   out_col_r, out_left_r, out_right_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  step_ctl_t                 step_ctl;
  logic signed [VW-1:0]      step_x, step_y;
  logic signed [Z_W-1:0]     step_z;

  logic signed [STATE_W:0]   diff;
  logic signed [MUL_P_W-1:0] lag_round;
  logic signed [MUL_P_W-1:0] lag_delta;
  logic signed [STATE_W+1:0] col_sum;
  logic signed [STATE_W-1:0] col_nxt;

  logic signed [VW-1:0]      vx, vy;
  logic                      vx_zero, vy_pos, vy_neg;
  logic signed [STATE_W-1:0] axis_ang;
  logic signed [Z_W:0]       z_round;
  logic signed [STATE_W-1:0] wheel_ang;

  logic in_acc, out_free, iter_last;

  als_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  als_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  als_cordic_step u_step (
    .x_i (cx_r),
    .y_i (cy_r),
    .z_i (cz_r),
    .ctl (step_ctl),
    .x_o (step_x),
    .y_o (step_y),
    .z_o (step_z)
  );

  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign iter_last = (iter_r == ITER_LAST);

  // lag step: delta = round-half-up((cmd - col) * gain / 2^16), then clamp
  assign diff      = (STATE_W+1)'(cmd_r) - (STATE_W+1)'(column_r);
  assign lag_round = mul_p + LAG_RND;
  assign lag_delta = lag_round >>> LAG_FRAC;
  assign col_sum   = (STATE_W+2)'(column_r) + (STATE_W+2)'(lag_delta);
  assign col_nxt   = clamp_hp((Z_W+1)'(col_sum));

  // vector for the wheel in turn: x = 2Lc -+ ws, y = 2Ls
  assign vx      = side_r ? ((lc_r <<< 1) + ws_r) : ((lc_r <<< 1) - ws_r);
  assign vy      = ls_r <<< 1;
  assign vx_zero = (vx == '0);
  assign vy_neg  = vy[VW-1];
  assign vy_pos  = !vy[VW-1] && (vy != '0);
  assign axis_ang = vy_pos ? HALF_PI : (vy_neg ? -HALF_PI : '0);

  // Q30 angle back to the output format
  assign z_round   = (Z_W+1)'(cz_r) + VEC_RND;
  assign wheel_ang = clamp_hp(z_round >>> ZSH);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_LAG_MUL;
      ST_LAG_MUL:  state_nxt = ST_LAG_UPD;
      ST_LAG_UPD:  state_nxt = (col_nxt == '0) ? ST_DONE : ST_ROT;
      ST_ROT:      if (iter_last) state_nxt = ST_MUL_LS;
      ST_MUL_LS:   state_nxt = ST_MUL_LC;
      ST_MUL_LC:   state_nxt = ST_MUL_WS;
      ST_MUL_WS:   state_nxt = ST_MUL_END;
      ST_MUL_END:  state_nxt = ST_VEC_INIT;
      ST_VEC_INIT: begin
        if (!vx_zero) begin
          state_nxt = ST_VEC;
        end else if (side_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_VEC:      if (iter_last) state_nxt = ST_VEC_END;
      ST_VEC_END:  state_nxt = side_r ? ST_DONE : ST_VEC_INIT;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, multiplier operands, step unit mode
  always_comb begin
    in_ready       = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    step_ctl.mode  = CM_ROTATE;
    step_ctl.shift = iter_r;
    case (state_r)
      ST_IDLE:    in_ready = 1'b1;
      ST_LAG_MUL: begin
        mul_a = MUL_A_W'(diff);
        mul_b = signed'(MUL_B_W'(cfg.lag_gain));
      end
      ST_MUL_LS: begin
        mul_a = MUL_A_W'(cy_r);
        mul_b = signed'(MUL_B_W'(cfg.wheelbase));
      end
      ST_MUL_LC: begin
        mul_a = MUL_A_W'(cx_r);
        mul_b = signed'(MUL_B_W'(cfg.wheelbase));
      end
      ST_MUL_WS: begin
        mul_a = MUL_A_W'(cy_r);
        mul_b = signed'(MUL_B_W'(cfg.track));
      end
      ST_VEC:     step_ctl.mode = CM_VECTOR;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      column_r    <= '0;
      iter_r      <= '0;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LAG_UPD: begin
          column_r <= col_nxt;
          iter_r   <= '0;
          side_r   <= 1'b0;
        end
        ST_ROT, ST_VEC: iter_r <= iter_last ? '0 : iter_r + 1'b1;
        ST_VEC_INIT: begin
          iter_r <= '0;
          if (vx_zero) side_r <= 1'b1;
        end
        ST_VEC_END: side_r <= 1'b1;
        default: ;
      endcase
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) cmd_r <= in_steer_command;
    case (state_r)
      ST_LAG_UPD: begin
        cx_r    <= ROT_X0;
        cy_r    <= '0;
        cz_r    <= Z_W'(col_nxt) <<< ZSH;
        left_r  <= '0;
        right_r <= '0;
      end
      ST_ROT, ST_VEC: begin
        cx_r <= step_x;
        cy_r <= step_y;
        cz_r <= step_z;
      end
      ST_MUL_LC:  ls_r <= VW'(mul_p);
      ST_MUL_WS:  lc_r <= VW'(mul_p);
      ST_MUL_END: ws_r <= VW'(mul_p);
      ST_VEC_INIT: begin
        // fold into the right half plane so the angle stays within +-pi/2
        cx_r <= vx[VW-1] ? -vx : vx;
        cy_r <= vx[VW-1] ? -vy : vy;
        cz_r <= '0;
        if (vx_zero) begin
          if (side_r) right_r <= ANG_W'(axis_ang);
          else        left_r  <= ANG_W'(axis_ang);
        end
      end
      ST_VEC_END: begin
        if (side_r) right_r <= ANG_W'(wheel_ang);
        else        left_r  <= ANG_W'(wheel_ang);
      end
      ST_DONE: begin
        if (out_free) begin
          out_col_r   <= ANG_W'(column_r);
          out_left_r  <= left_r;
          out_right_r <= right_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_column_angle      = out_col_r;
  assign out_left_wheel_angle  = out_left_r;
  assign out_right_wheel_angle = out_right_r;

  // column result never leaves +-pi/2
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_column_angle <= HALF_PI) && (out_column_angle >= -HALF_PI))
    else $error("column angle out of range");

  // wheel results never leave +-pi/2
  a_wheel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_wheel_angle <= HALF_PI) && (out_left_wheel_angle >= -HALF_PI)
               && (out_right_wheel_angle <= HALF_PI) && (out_right_wheel_angle >= -HALF_PI))
    else $error("wheel angle out of range");

  // straight column gives straight wheels
  a_zero_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_column_angle == '0) |->
      (out_left_wheel_angle == '0) && (out_right_wheel_angle == '0))
    else $error("nonzero wheel angle on straight column");

  // an accepted word starts the lag multiply
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_LAG_MUL))
    else $error("accepted word did not start");

  // the last rotation step leads to the multiplies with the iteration count cleared
  a_rot_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT && iter_last) |=> (state_r == ST_MUL_LS) && (iter_r == '0))
    else $error("rotation sequence broken");

endmodule
